// ===== design/xccm_pkg.sv =====
// ----------------------------------------------------------------------------
// xccm_pkg
// Shared types and constants of the XOR-convolution pair counter.
// ----------------------------------------------------------------------------
package xccm_pkg;

  // Default for the top-level dimension limit
  localparam int unsigned MAX_DIM_DEF = 6;
  // Hard limit on the dimension, set by the width of the index field
  localparam int unsigned DIM_LIMIT   = 6;

  localparam int unsigned DIM_W = 3;   // dimension register
  localparam int unsigned IDX_W = 6;   // count_index
  localparam int unsigned CNT_W = 7;   // pair_count

  typedef struct packed {
    logic left_occupied;
    logic right_occupied;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] count_index;
    logic [CNT_W-1:0] pair_count;
    logic             last_count;
  } out_req_t;

  // Datapath operations issued by the sequencer
  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_READ,
    DP_SUM,
    DP_DIFF,
    DP_PROD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_b;   // butterfly works on the right vector store
  } dp_ctrl_t;

  typedef struct packed {
    logic load;      // load the output register this cycle
    logic last;      // final count of the run
  } res_ctrl_t;

endpackage

// ===== design/xor_convolution_count_mod_core.sv =====
// ----------------------------------------------------------------------------
// xor_convolution_count_mod_core
// XOR-convolution pair counter over two occupancy vectors of length 2^p.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   cfg     | in        | cfg_we_i                | cfg_wdata_i (dimension)
//   in      | in        | in_valid_i/in_stall_o   | in_req_i (left, right bit)
//   out     | out       | out_valid_o/out_stall_i | out_req_o (index, count, last)
//
// Loading takes one request per cycle; the last index starts the run.
// A run then performs three transforms (each butterfly reads both entries,
// then writes the sum and then the difference on the single write port of
// each store), the element-wise products and the unload of the counts.
// No clearing pass after reset. Output stall holds the unload sequencer;
// input is stalled from the last load until the final count is registered.
// ----------------------------------------------------------------------------
module xor_convolution_count_mod_core #(
  parameter int unsigned MAX_DIM = xccm_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [xccm_pkg::DIM_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  xccm_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output xccm_pkg::out_req_t          out_req_o
);

  localparam int unsigned DIM_CAP =
      (MAX_DIM < xccm_pkg::DIM_LIMIT) ? MAX_DIM : xccm_pkg::DIM_LIMIT;
  localparam int unsigned ADDR_W = DIM_CAP;

  logic [xccm_pkg::DIM_W-1:0] dimension_q;
  logic [xccm_pkg::DIM_W-1:0] shift;
  logic [xccm_pkg::CNT_W-1:0] count;
  logic [ADDR_W-1:0]          addr_lo, addr_hi;
  xccm_pkg::dp_ctrl_t         ctrl;
  xccm_pkg::res_ctrl_t        res;
  xccm_pkg::out_req_t         out_req_q;
  logic                       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimension_q <= '0;
    end else if (cfg_we_i) begin
      dimension_q <= cfg_wdata_i;
    end
  end

  xccm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dim_i      (dimension_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_full_i (out_valid_q && out_stall_i),
    .ctrl_o     (ctrl),
    .res_o      (res),
    .addr_lo_o  (addr_lo),
    .addr_hi_o  (addr_hi),
    .shift_o    (shift)
  );

  xccm_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .addr_lo_i (addr_lo),
    .addr_hi_i (addr_hi),
    .left_i    (in_req_i.left_occupied),
    .right_i   (in_req_i.right_occupied),
    .shift_i   (shift),
    .count_o   (count)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_req_q.count_index <= xccm_pkg::IDX_W'(addr_lo);
      out_req_q.pair_count  <= count;
      out_req_q.last_count  <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // never overwrite a pending result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> !out_valid_q)
    else $error("result loaded over a pending result");

  a_no_result_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> in_stall_o)
    else $error("result produced while accepting requests");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load && res.last |=> !in_stall_o)
    else $error("input still stalled after final count");

  a_stall_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("run started without an accepted request");

endmodule

// ===== design/xccm_dpath.sv =====
// ----------------------------------------------------------------------------
// xccm_dpath
// Vector stores and the shared butterfly / multiply unit.
// ----------------------------------------------------------------------------
module xccm_dpath #(
  parameter  int unsigned MAX_DIM = xccm_pkg::MAX_DIM_DEF,
  localparam int unsigned DIM_CAP =
      (MAX_DIM < xccm_pkg::DIM_LIMIT) ? MAX_DIM : xccm_pkg::DIM_LIMIT,
  localparam int unsigned ADDR_W  = DIM_CAP
) (
  input  logic                        clk_i,
  input  xccm_pkg::dp_ctrl_t          ctrl_i,
  input  logic [ADDR_W-1:0]           addr_lo_i,
  input  logic [ADDR_W-1:0]           addr_hi_i,
  input  logic                        left_i,
  input  logic                        right_i,
  input  logic [xccm_pkg::DIM_W-1:0]  shift_i,
  output logic [xccm_pkg::CNT_W-1:0]  count_o
);

  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  // Transformed 0/1 vectors stay within +-2^D, the final pass within +-2^(3D)
  localparam int unsigned OPW    = DIM_CAP + 2;
  localparam int unsigned DATA_W = 3 * DIM_CAP + 2;

  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [OPW-1:0]    mem_b [DEPTH];

  logic signed [DATA_W-1:0] ra_lo_q, ra_hi_q;
  logic signed [OPW-1:0]    rb_lo_q, rb_hi_q;
  logic signed [DATA_W-1:0] diff_q;

  logic signed [DATA_W-1:0] op_a, op_b, sum_w, diff_w, prod_w, scaled;
  logic signed [2*OPW-1:0]  prod_full;

  logic                     wa_en, wb_en;
  logic [ADDR_W-1:0]        wa_addr, wb_addr;
  logic signed [DATA_W-1:0] wa_data;
  logic signed [OPW-1:0]    wb_data;

  assign op_a      = ctrl_i.sel_b ? DATA_W'(rb_lo_q) : ra_lo_q;
  assign op_b      = ctrl_i.sel_b ? DATA_W'(rb_hi_q) : ra_hi_q;
  assign sum_w     = op_a + op_b;
  assign diff_w    = op_a - op_b;
  assign prod_full = signed'(ra_lo_q[OPW-1:0]) * rb_lo_q;
  assign prod_w    = DATA_W'(prod_full);

  always_comb begin
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wa_addr = addr_lo_i;
    wb_addr = addr_lo_i;
    wa_data = sum_w;
    wb_data = OPW'(sum_w);
    case (ctrl_i.op)
      xccm_pkg::DP_LOAD: begin
        wa_en   = 1'b1;
        wb_en   = 1'b1;
        wa_data = DATA_W'(left_i);
        wb_data = OPW'(right_i);
      end
      xccm_pkg::DP_SUM: begin
        wa_en = !ctrl_i.sel_b;
        wb_en = ctrl_i.sel_b;
      end
      xccm_pkg::DP_DIFF: begin
        wa_en   = !ctrl_i.sel_b;
        wb_en   = ctrl_i.sel_b;
        wa_addr = addr_hi_i;
        wb_addr = addr_hi_i;
        wa_data = diff_q;
        wb_data = OPW'(diff_q);
      end
      xccm_pkg::DP_PROD: begin
        wa_en   = 1'b1;
        wa_data = prod_w;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wa_en) begin
      mem_a[wa_addr] <= wa_data;
    end
    if (wb_en) begin
      mem_b[wb_addr] <= wb_data;
    end
    if (ctrl_i.op == xccm_pkg::DP_READ) begin
      ra_lo_q <= mem_a[addr_lo_i];
      ra_hi_q <= mem_a[addr_hi_i];
      rb_lo_q <= mem_b[addr_lo_i];
      rb_hi_q <= mem_b[addr_hi_i];
    end
    // hold the difference while the sum is written back
    if (ctrl_i.op == xccm_pkg::DP_SUM) begin
      diff_q <= diff_w;
    end
  end

  // Scale by 2^-p: the final values are exact multiples of 2^p
  assign scaled  = ra_lo_q >>> shift_i;
  assign count_o = xccm_pkg::CNT_W'(unsigned'(scaled));

endmodule

// ===== design/xccm_seq.sv =====
// ----------------------------------------------------------------------------
// xccm_seq
// Load counter and sequencer for the transform, multiply and unload passes.
// ----------------------------------------------------------------------------
module xccm_seq #(
  parameter  int unsigned MAX_DIM = xccm_pkg::MAX_DIM_DEF,
  localparam int unsigned DIM_CAP =
      (MAX_DIM < xccm_pkg::DIM_LIMIT) ? MAX_DIM : xccm_pkg::DIM_LIMIT,
  localparam int unsigned ADDR_W  = DIM_CAP
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [xccm_pkg::DIM_W-1:0]  dim_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        out_full_i,
  output xccm_pkg::dp_ctrl_t          ctrl_o,
  output xccm_pkg::res_ctrl_t         res_o,
  output logic [ADDR_W-1:0]           addr_lo_o,
  output logic [ADDR_W-1:0]           addr_hi_o,
  output logic [xccm_pkg::DIM_W-1:0]  shift_o
);

  localparam int unsigned DIM_W  = xccm_pkg::DIM_W;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_BF_RD  = 3'd1;
  localparam logic [2:0] ST_BF_W0  = 3'd2;
  localparam logic [2:0] ST_BF_W1  = 3'd3;
  localparam logic [2:0] ST_MUL_RD = 3'd4;
  localparam logic [2:0] ST_MUL_WR = 3'd5;
  localparam logic [2:0] ST_OUT_RD = 3'd6;
  localparam logic [2:0] ST_OUT_LD = 3'd7;

  localparam logic [1:0] PASS_LEFT  = 2'd0;
  localparam logic [1:0] PASS_RIGHT = 2'd1;
  localparam logic [1:0] PASS_FINAL = 2'd2;

  logic [2:0]        state_q, state_d;
  logic [1:0]        pass_q, pass_d;
  logic [DIM_W-1:0]  stage_q, stage_d;
  logic [DIM_W-1:0]  p_q, p_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] pos_q, pos_d;

  logic [DIM_W-1:0]  p_cur;
  logic [ADDR_W:0]   len_cur, len_run;
  logic [ADDR_W-1:0] idx, elem_last, half_last;
  logic [ADDR_W-1:0] low_mask, bf_lo, bf_hi;
  logic              load_last, in_bf;

  // Load side uses the live dimension
  assign p_cur     = (dim_i > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : dim_i;
  assign len_cur   = (ADDR_W + 1)'(1) << p_cur;
  assign idx       = ({1'b0, pos_q} >= len_cur) ? '0 : pos_q;
  assign load_last = ({1'b0, idx} == len_cur - 1'b1);

  assign len_run   = (ADDR_W + 1)'(1) << p_q;
  assign elem_last = ADDR_W'(len_run - 1'b1);
  assign half_last = ADDR_W'((len_run >> 1) - 1'b1);

  // Butterfly pair: insert a zero at bit stage of the pair count
  assign low_mask = ~({ADDR_W{1'b1}} << stage_q);
  assign bf_lo    = ((cnt_q & ~low_mask) << 1) | (cnt_q & low_mask);
  assign bf_hi    = bf_lo | (ADDR_W'(1) << stage_q);

  assign in_bf = (state_q == ST_BF_RD) || (state_q == ST_BF_W0) || (state_q == ST_BF_W1);

  assign addr_lo_o  = (state_q == ST_LOAD) ? idx : (in_bf ? bf_lo : cnt_q);
  assign addr_hi_o  = bf_hi;
  assign shift_o    = p_q;
  assign in_stall_o = (state_q != ST_LOAD);

  always_comb begin
    state_d      = state_q;
    pass_d       = pass_q;
    stage_d      = stage_q;
    p_d          = p_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    ctrl_o.op    = xccm_pkg::DP_IDLE;
    ctrl_o.sel_b = (pass_q == PASS_RIGHT);
    res_o.load   = 1'b0;
    res_o.last   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          ctrl_o.op = xccm_pkg::DP_LOAD;
          if (load_last) begin
            pos_d   = '0;
            p_d     = p_cur;
            cnt_d   = '0;
            stage_d = '0;
            pass_d  = PASS_LEFT;
            state_d = (p_cur == '0) ? ST_MUL_RD : ST_BF_RD;
          end else begin
            pos_d = ADDR_W'(idx + 1'b1);
          end
        end
      end
      ST_BF_RD: begin
        ctrl_o.op = xccm_pkg::DP_READ;
        state_d   = ST_BF_W0;
      end
      ST_BF_W0: begin
        ctrl_o.op = xccm_pkg::DP_SUM;
        state_d   = ST_BF_W1;
      end
      ST_BF_W1: begin
        ctrl_o.op = xccm_pkg::DP_DIFF;
        state_d   = ST_BF_RD;
        if (cnt_q == half_last) begin
          cnt_d = '0;
          if (stage_q == p_q - 1'b1) begin
            stage_d = '0;
            case (pass_q)
              PASS_LEFT:  pass_d  = PASS_RIGHT;
              PASS_RIGHT: state_d = ST_MUL_RD;
              default:    state_d = ST_OUT_RD;
            endcase
          end else begin
            stage_d = DIM_W'(stage_q + 1'b1);
          end
        end else begin
          cnt_d = ADDR_W'(cnt_q + 1'b1);
        end
      end
      ST_MUL_RD: begin
        ctrl_o.op = xccm_pkg::DP_READ;
        state_d   = ST_MUL_WR;
      end
      ST_MUL_WR: begin
        ctrl_o.op = xccm_pkg::DP_PROD;
        if (cnt_q == elem_last) begin
          cnt_d   = '0;
          pass_d  = PASS_FINAL;
          state_d = (p_q == '0) ? ST_OUT_RD : ST_BF_RD;
        end else begin
          cnt_d   = ADDR_W'(cnt_q + 1'b1);
          state_d = ST_MUL_RD;
        end
      end
      ST_OUT_RD: begin
        // read only when the output register is free by the next cycle
        if (!out_full_i) begin
          ctrl_o.op = xccm_pkg::DP_READ;
          state_d   = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        res_o.load = 1'b1;
        res_o.last = (cnt_q == elem_last);
        if (cnt_q == elem_last) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else begin
          cnt_d   = ADDR_W'(cnt_q + 1'b1);
          state_d = ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pass_q  <= PASS_LEFT;
      stage_q <= '0;
      p_q     <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      stage_q <= stage_d;
      p_q     <= p_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== test/tb_xor_convolution_count_mod_core.sv =====
// ----------------------------------------------------------------------------
// tb_xor_convolution_count_mod_core
// Self-checking bench for the XOR-convolution pair counter. Occupancy bits
// are loaded at several dimensions, including the oversized setting, partial
// loads and restarts after a shrink. Every emitted count is compared against
// a brute-force XOR-convolution computed in the bench.
// ----------------------------------------------------------------------------
module tb_xor_convolution_count_mod_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TB_MAX_DIM  = xccm_pkg::MAX_DIM_DEF;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 4000;
  localparam int          SETTLE      = 40;
  localparam int          RANDOM_ITEMS = 110;

  typedef enum int {
    FILL_ZERO,
    FILL_ONE,
    FILL_RANDOM,
    FILL_SPARSE
  } fill_e;

  // Tracks load state and the expected counts of each completed load.
  class pair_count_board;
    logic [xccm_pkg::DIM_W-1:0] dimension;
    int                         load_pos;
    bit                         left_bits[64];
    bit                         right_bits[64];
    xccm_pkg::out_req_t         counts_q[$];
    int                         errors;

    function new();
      dimension = '0;
      load_pos  = 0;
      errors    = 0;
    endfunction

    function int vec_len();
      int p;
      p = dimension;
      if (p > TB_MAX_DIM) p = TB_MAX_DIM;
      if (p > xccm_pkg::DIM_LIMIT) p = xccm_pkg::DIM_LIMIT;
      return 1 << p;
    endfunction

    // Requests still needed before the current load completes.
    function int items_to_run();
      int n;
      n = vec_len();
      return (load_pos >= n) ? n : n - load_pos;
    endfunction

    function void write_dimension(logic [xccm_pkg::DIM_W-1:0] v);
      dimension = v;
    endfunction

    function void note_request(xccm_pkg::in_req_t req);
      int                 n;
      int                 idx;
      int                 cnt;
      xccm_pkg::out_req_t res;
      n   = vec_len();
      idx = (load_pos >= n) ? 0 : load_pos;
      left_bits[idx]  = req.left_occupied;
      right_bits[idx] = req.right_occupied;
      if (idx != n - 1) begin
        load_pos = (idx + 1) & 'h7F;
        return;
      end
      load_pos = 0;
      for (int z = 0; z < n; z++) begin
        cnt = 0;
        for (int x = 0; x < n; x++) begin
          cnt += int'(left_bits[x] & right_bits[x ^ z]);
        end
        if (cnt > 127) cnt = 127;
        res.count_index = xccm_pkg::IDX_W'(z);
        res.pair_count  = xccm_pkg::CNT_W'(cnt);
        res.last_count  = (z == n - 1);
        counts_q.push_back(res);
      end
    endfunction

    function void check_result(xccm_pkg::out_req_t got);
      xccm_pkg::out_req_t exp_res;
      if (counts_q.size() == 0) begin
        $error("unexpected result: count_index %0d pair_count %0d last_count %0d",
               got.count_index, got.pair_count, got.last_count);
        errors++;
        return;
      end
      exp_res = counts_q.pop_front();
      if (got.count_index !== exp_res.count_index) begin
        $error("count_index mismatch: expected %0d, actual %0d",
               exp_res.count_index, got.count_index);
        errors++;
      end
      if (got.pair_count !== exp_res.pair_count) begin
        $error("pair_count mismatch: expected %0d, actual %0d",
               exp_res.pair_count, got.pair_count);
        errors++;
      end
      if (got.last_count !== exp_res.last_count) begin
        $error("last_count mismatch: expected %0d, actual %0d",
               exp_res.last_count, got.last_count);
        errors++;
      end
    endfunction

    function int pending();
      return counts_q.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [xccm_pkg::DIM_W-1:0] cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  xccm_pkg::in_req_t          in_req_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  xccm_pkg::out_req_t         out_req_o;

  pair_count_board board;
  int              item_count;
  int              cycle_count = 0;
  bit              quiet;
  int              hold_req;
  int              hold_seen   = 0;
  int              hold_left   = 0;
  int              rx_gap      = 0;

  xor_convolution_count_mod_core #(
    .MAX_DIM(TB_MAX_DIM)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic draw_bit(fill_e mode);
    case (mode)
      FILL_ZERO: return 1'b0;
      FILL_ONE:  return 1'b1;
      FILL_SPARSE: return ($urandom_range(0, 4) == 0);
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [xccm_pkg::DIM_W-1:0] pick_dimension();
    // favor short vectors, the longest ones cost 64 requests per load
    if ($urandom_range(0, 9) < 8) return xccm_pkg::DIM_W'($urandom_range(0, 5));
    return xccm_pkg::DIM_W'($urandom_range(6, 7));
  endfunction

  function automatic fill_e pick_fill();
    return fill_e'($urandom_range(0, 3));
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check accepted counts, then stall for a drawn number of cycles; a hold request also stalls it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        board.check_result(out_req_o);
        rx_gap = draw_gap();
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic l, input logic r);
    int                gap;
    xccm_pkg::in_req_t req;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.left_occupied  = l;
    req.right_occupied = r;
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req);
    item_count++;
  endtask

  task automatic send_partial(input int n, input fill_e mode);
    for (int i = 0; i < n; i++) send_request(draw_bit(mode), draw_bit(mode));
  endtask

  task automatic send_run(input fill_e mode);
    send_partial(board.items_to_run(), mode);
  endtask

  // Drain all pending counts, then let the block settle before a write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_dimension(input logic [xccm_pkg::DIM_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.write_dimension(v);
  endtask

  initial begin
    int n;
    board       = new();
    item_count  = 0;
    quiet       = 1'b0;
    hold_req    = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dimension gives one-element vectors
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b0);
    wait_idle();
    write_dimension(xccm_pkg::DIM_W'(1));
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
    wait_idle();
    write_dimension(xccm_pkg::DIM_W'(2));
    send_partial(4, FILL_ONE);
    // oversized setting, then shrink below the load position: load restarts
    wait_idle();
    write_dimension(xccm_pkg::DIM_W'(7));
    send_partial(5, FILL_RANDOM);
    wait_idle();
    write_dimension(xccm_pkg::DIM_W'(2));
    send_run(FILL_SPARSE);
    // growing mid-load keeps the position
    send_partial(2, FILL_RANDOM);
    wait_idle();
    write_dimension(xccm_pkg::DIM_W'(3));
    send_run(FILL_RANDOM);

    // full-length load while the receiver holds off; the next requests back up
    wait_idle();
    write_dimension(xccm_pkg::DIM_W'(6));
    hold_req++;
    send_run(FILL_ONE);
    send_partial(6, FILL_RANDOM);

    while (item_count < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 2) != 0) begin
          wait_idle();
          write_dimension(pick_dimension());
        end
        send_run(pick_fill());
      end else begin
        n = board.items_to_run();
        if (n > 1) send_partial($urandom_range(1, n - 1), pick_fill());
        wait_idle();
        write_dimension(pick_dimension());
      end
    end

    quiet = 1'b0;
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/xccm_pkg.sv
design/xccm_dpath.sv
design/xccm_seq.sv
design/xor_convolution_count_mod_core.sv
test/tb_xor_convolution_count_mod_core.sv
